// ===== sv/bfrc_pkg.sv =====
`default_nettype none

package bfrc_pkg;

   // field widths
   localparam int FIELD_W   = 32;
   localparam int RATE_W    = 20;
   localparam int SPACING_W = 30;
   localparam int GAIN_W    = 8;
   localparam int STEP_W    = 16;
   localparam int MODE_W    = 2;

   // signed difference of two feedback fields, and its product with a Q0.8 gain
   localparam int ERR_W  = FIELD_W + 1;
   localparam int PROD_W = ERR_W + GAIN_W;
   localparam int FRAC_W = 8;

   // wide enough for rate plus two scaled terms
   localparam int SUM_W = ERR_W + 3;

   localparam longint RATE_MAX = 1048575;

   localparam logic [SPACING_W-1:0] NS_PER_SECOND = SPACING_W'(1000000000);

   // step counters
   localparam int MUL_CNT_W = $clog2(GAIN_W + 1);
   localparam int DIV_CNT_W = $clog2(SPACING_W + 1);

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = RATE_W;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RATE_MODE     = 3'd0,
      CSR_STEP_SIZE     = 3'd1,
      CSR_DECREASE_GAIN = 3'd2,
      CSR_ERROR_GAIN    = 3'd3,
      CSR_DAMPING_GAIN  = 3'd4,
      CSR_INITIAL_RATE  = 3'd5
   } csr_index_type;

   typedef enum logic [MODE_W-1:0] {
      MODE_ADDITIVE = 2'd0,
      MODE_AIMD     = 2'd1,
      MODE_PROP     = 2'd2,
      MODE_DAMPED   = 2'd3
   } rate_mode_type;

endpackage

`default_nettype wire

// ===== sv/bfrc_req_if.sv =====
`default_nettype none

interface bfrc_req_if;
   logic                          valid;
   logic                          ready;
   logic                          restart;
   logic [bfrc_pkg::FIELD_W-1:0]  occupancy;
   logic [bfrc_pkg::FIELD_W-1:0]  target_level;
   logic [bfrc_pkg::FIELD_W-1:0]  reference_rate;

   modport source (
      output valid, restart, occupancy, target_level, reference_rate,
      input  ready
   );

   modport sink (
      input  valid, restart, occupancy, target_level, reference_rate,
      output ready
   );
endinterface

`default_nettype wire

// ===== sv/bfrc_rsp_if.sv =====
`default_nettype none

interface bfrc_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [bfrc_pkg::RATE_W-1:0]    new_rate;
   logic [bfrc_pkg::SPACING_W-1:0] spacing_ns;
   logic                           clamped;

   modport source (
      output valid, new_rate, spacing_ns, clamped,
      input  ready
   );

   modport sink (
      input  valid, new_rate, spacing_ns, clamped,
      output ready
   );
endinterface

`default_nettype wire

// ===== sv/bfrc_mul_serial.sv =====
`default_nettype none

// Shift-add multiplier: signed operand times unsigned Q0.8 gain,
// one gain bit per cycle, done pulses after the last bit.
module bfrc_mul_serial (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   input  wire logic signed [bfrc_pkg::ERR_W-1:0]   multiplicand,
   input  wire logic        [bfrc_pkg::GAIN_W-1:0]  gain,
   output logic                                     done,
   output logic signed      [bfrc_pkg::PROD_W-1:0]  product
);

   logic                                   busy_ff, busy_in;
   logic                                   done_ff, done_in;
   logic [bfrc_pkg::MUL_CNT_W-1:0]         count_ff, count_in;
   logic signed [bfrc_pkg::PROD_W-1:0]     acc_ff, acc_in;
   logic signed [bfrc_pkg::PROD_W-1:0]     mcand_ff, mcand_in;
   logic [bfrc_pkg::GAIN_W-1:0]            gain_ff, gain_in;

   // one partial product per cycle, gain shifted out LSB first
   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      acc_in   = acc_ff;
      mcand_in = mcand_ff;
      gain_in  = gain_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         acc_in   = '0;
         mcand_in = bfrc_pkg::PROD_W'(multiplicand);
         gain_in  = gain;
      end else if (busy_ff) begin
         if (gain_ff[0]) begin
            acc_in = acc_ff + mcand_ff;
         end
         mcand_in = mcand_ff <<< 1;
         gain_in  = gain_ff >> 1;
         count_in = count_ff + 1'b1;
         if (count_ff == bfrc_pkg::MUL_CNT_W'(bfrc_pkg::GAIN_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff <= count_in;
      acc_ff   <= acc_in;
      mcand_ff <= mcand_in;
      gain_ff  <= gain_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

`default_nettype wire

// ===== sv/bfrc_divider.sv =====
`default_nettype none

// Restoring divider for one billion over the rate, one quotient bit a cycle.
// Quotient holds after done until the next start.
module bfrc_divider (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   input  wire logic [bfrc_pkg::RATE_W-1:0]      divisor,
   output logic                                  done,
   output logic [bfrc_pkg::SPACING_W-1:0]        quotient
);

   logic                                 busy_ff, busy_in;
   logic                                 done_ff, done_in;
   logic [bfrc_pkg::DIV_CNT_W-1:0]       count_ff, count_in;
   logic [bfrc_pkg::RATE_W-1:0]          divisor_ff, divisor_in;
   logic [bfrc_pkg::RATE_W-1:0]          rem_ff, rem_in;
   logic [bfrc_pkg::SPACING_W-1:0]       dvd_ff, dvd_in;
   logic [bfrc_pkg::RATE_W:0]            trial;
   logic [bfrc_pkg::RATE_W:0]            diff;
   logic                                 qbit;

   // dividend bits shift out the top, quotient bits shift in the bottom
   always_comb begin
      trial = {rem_ff, dvd_ff[bfrc_pkg::SPACING_W-1]};
      diff  = trial - {1'b0, divisor_ff};
      qbit  = (trial >= {1'b0, divisor_ff});

      busy_in    = busy_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      divisor_in = divisor_ff;
      rem_in     = rem_ff;
      dvd_in     = dvd_ff;
      if (start) begin
         busy_in    = 1'b1;
         count_in   = '0;
         divisor_in = divisor;
         rem_in     = '0;
         dvd_in     = bfrc_pkg::NS_PER_SECOND;
      end else if (busy_ff) begin
         // remainder stays below the divisor, so the low bits are enough
         rem_in   = qbit ? diff[bfrc_pkg::RATE_W-1:0] : trial[bfrc_pkg::RATE_W-1:0];
         dvd_in   = {dvd_ff[bfrc_pkg::SPACING_W-2:0], qbit};
         count_in = count_ff + 1'b1;
         if (count_ff == bfrc_pkg::DIV_CNT_W'(bfrc_pkg::SPACING_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff   <= count_in;
      divisor_ff <= divisor_in;
      rem_ff     <= rem_in;
      dvd_ff     <= dvd_in;
   end

   assign done     = done_ff;
   assign quotient = dvd_ff;

endmodule

`default_nettype wire

// ===== sv/buffer_feedback_rate_control_unit.sv =====
`default_nettype none

// Channel   Dir   Handshake        Beat contents
// req_bus   in    valid/ready      restart, occupancy, target_level, reference_rate
// rsp_bus   out   valid/ready      new_rate, spacing_ns, clamped
// csr_*     in    csr_we only      csr_index, csr_wdata
//
// Each beat goes through the two shift-add gain multipliers (one gain bit a
// cycle), a combine-and-saturate state, the restoring spacing divider, and a
// load into the output register once it is free or its result is being taken.
// A new beat is taken once the previous one has reached the output register,
// even while that result still waits on rsp_bus.ready.
// Reset is synchronous and loads the register defaults and a rate of 1.
module buffer_feedback_rate_control_unit (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   bfrc_req_if.sink                                  req_bus,
   bfrc_rsp_if.source                                rsp_bus,
   input  wire logic                                 csr_we,
   input  wire logic [bfrc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [bfrc_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int RATE_W = bfrc_pkg::RATE_W;
   localparam int SUM_W  = bfrc_pkg::SUM_W;
   localparam int ERR_W  = bfrc_pkg::ERR_W;
   localparam int FRAC_W = bfrc_pkg::FRAC_W;
   localparam logic signed [SUM_W-1:0] SUM_ONE  = SUM_W'(1);
   localparam logic signed [SUM_W-1:0] SUM_MAX  = SUM_W'(bfrc_pkg::RATE_MAX);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_COMB,
      ST_DIV,
      ST_OUT
   } state_type;

   state_type                         state_ff, state_in;

   // configuration registers
   bfrc_pkg::rate_mode_type           rate_mode_ff;
   logic [bfrc_pkg::STEP_W-1:0]       step_size_ff;
   logic [bfrc_pkg::GAIN_W-1:0]       decrease_gain_ff;
   logic [bfrc_pkg::GAIN_W-1:0]       error_gain_ff;
   logic [bfrc_pkg::GAIN_W-1:0]       damping_gain_ff;
   logic [RATE_W-1:0]                 initial_rate_ff;

   // rate state and per-beat context
   logic [RATE_W-1:0]                 send_rate_ff, send_rate_in;
   logic                              restart_ff, restart_in;
   logic                              err_neg_ff, err_neg_in;
   logic                              err_zero_ff, err_zero_in;
   logic                              clamped_ff, clamped_in;

   // output register
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [RATE_W-1:0]                 rsp_rate_ff, rsp_rate_in;
   logic [bfrc_pkg::SPACING_W-1:0]    rsp_spacing_ff, rsp_spacing_in;
   logic                              rsp_clamped_ff, rsp_clamped_in;

   logic                              req_fire;
   logic                              rsp_fire;
   logic signed [ERR_W-1:0]           err_now;
   logic signed [ERR_W-1:0]           rate_ext;
   logic signed [ERR_W-1:0]           damp_mcand;
   logic                              mul_e_done;
   logic                              mul_d_done;
   logic signed [bfrc_pkg::PROD_W-1:0] prod_e;
   logic signed [bfrc_pkg::PROD_W-1:0] prod_d;
   logic                              div_start;
   logic                              div_done;
   logic [bfrc_pkg::SPACING_W-1:0]    quotient;

   logic signed [SUM_W-1:0]           rate_s;
   logic signed [SUM_W-1:0]           step_s;
   logic signed [SUM_W-1:0]           term_e;
   logic signed [SUM_W-1:0]           term_d;
   logic signed [SUM_W-1:0]           next_sum;
   logic [RATE_W-1:0]                 sat_rate;
   logic                              sat_hit;

   assign req_fire = req_bus.valid && req_bus.ready;
   assign rsp_fire = rsp_valid_ff && rsp_bus.ready;

   // operands for the two gain multipliers, from the beat and the current send rate
   always_comb begin
      err_now  = $signed({1'b0, req_bus.target_level}) - $signed({1'b0, req_bus.occupancy});
      rate_ext = $signed({{(ERR_W - RATE_W){1'b0}}, send_rate_ff});
      if (rate_mode_ff == bfrc_pkg::MODE_AIMD) begin
         damp_mcand = rate_ext;
      end else begin
         damp_mcand = rate_ext - $signed({1'b0, req_bus.reference_rate});
      end
   end

   function automatic logic [bfrc_pkg::GAIN_W-1:0] decrease_or_damp_gain(
      input bfrc_pkg::rate_mode_type     mode,
      input logic [bfrc_pkg::GAIN_W-1:0] dec_gain,
      input logic [bfrc_pkg::GAIN_W-1:0] damp_gain
   );
      return (mode == bfrc_pkg::MODE_AIMD) ? dec_gain : damp_gain;
   endfunction

   bfrc_mul_serial u_mul_err (
      .clock        (clock),
      .reset        (reset),
      .start        (req_fire),
      .multiplicand (err_now),
      .gain         (error_gain_ff),
      .done         (mul_e_done),
      .product      (prod_e)
   );

   bfrc_mul_serial u_mul_damp (
      .clock        (clock),
      .reset        (reset),
      .start        (req_fire),
      .multiplicand (damp_mcand),
      .gain         (decrease_or_damp_gain(rate_mode_ff, decrease_gain_ff, damping_gain_ff)),
      .done         (mul_d_done),
      .product      (prod_d)
   );

   // rate update law, floors are arithmetic shifts of the Q0.8 products
   always_comb begin
      rate_s = $signed({{(SUM_W - RATE_W){1'b0}}, send_rate_ff});
      step_s = $signed({{(SUM_W - bfrc_pkg::STEP_W){1'b0}}, step_size_ff});
      term_e = $signed(SUM_W'(prod_e >>> FRAC_W));
      term_d = $signed(SUM_W'(prod_d >>> FRAC_W));
      if (restart_ff) begin
         next_sum = $signed({{(SUM_W - RATE_W){1'b0}}, initial_rate_ff});
      end else begin
         case (rate_mode_ff)
            bfrc_pkg::MODE_ADDITIVE: begin
               if (err_zero_ff) begin
                  next_sum = rate_s;
               end else if (err_neg_ff) begin
                  next_sum = rate_s - step_s;
               end else begin
                  next_sum = rate_s + step_s;
               end
            end
            bfrc_pkg::MODE_AIMD: begin
               if (err_zero_ff) begin
                  next_sum = rate_s;
               end else if (err_neg_ff) begin
                  next_sum = term_d;
               end else begin
                  next_sum = rate_s + step_s;
               end
            end
            bfrc_pkg::MODE_PROP: begin
               next_sum = rate_s + term_e;
            end
            default: begin
               next_sum = rate_s + term_e - term_d;
            end
         endcase
      end

      // saturate to 1..RATE_MAX
      if (next_sum < SUM_ONE) begin
         sat_rate = RATE_W'(1);
         sat_hit  = 1'b1;
      end else if (next_sum > SUM_MAX) begin
         sat_rate = RATE_W'(bfrc_pkg::RATE_MAX);
         sat_hit  = 1'b1;
      end else begin
         sat_rate = next_sum[RATE_W-1:0];
         sat_hit  = 1'b0;
      end
   end

   assign div_start = (state_ff == ST_COMB);

   bfrc_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .divisor  (sat_rate),
      .done     (div_done),
      .quotient (quotient)
   );

   // sequencer and output register
   always_comb begin
      state_in       = state_ff;
      send_rate_in   = send_rate_ff;
      restart_in     = restart_ff;
      err_neg_in     = err_neg_ff;
      err_zero_in    = err_zero_ff;
      clamped_in     = clamped_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_rate_in    = rsp_rate_ff;
      rsp_spacing_in = rsp_spacing_ff;
      rsp_clamped_in = rsp_clamped_ff;

      if (rsp_fire) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               restart_in  = req_bus.restart;
               err_neg_in  = err_now[ERR_W-1];
               err_zero_in = (err_now == '0);
               state_in    = ST_MUL;
            end
         end
         ST_MUL: begin
            if (mul_e_done && mul_d_done) begin
               state_in = ST_COMB;
            end
         end
         ST_COMB: begin
            send_rate_in = sat_rate;
            clamped_in   = sat_hit;
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_rate_in    = send_rate_ff;
               rsp_spacing_in = quotient;
               rsp_clamped_in = clamped_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         send_rate_ff <= RATE_W'(1);
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         send_rate_ff <= send_rate_in;
      end
      restart_ff     <= restart_in;
      err_neg_ff     <= err_neg_in;
      err_zero_ff    <= err_zero_in;
      clamped_ff     <= clamped_in;
      rsp_rate_ff    <= rsp_rate_in;
      rsp_spacing_ff <= rsp_spacing_in;
      rsp_clamped_ff <= rsp_clamped_in;
   end

   // register writes, indexes past the list are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         rate_mode_ff     <= bfrc_pkg::MODE_ADDITIVE;
         step_size_ff     <= bfrc_pkg::STEP_W'(1);
         decrease_gain_ff <= bfrc_pkg::GAIN_W'(128);
         error_gain_ff    <= bfrc_pkg::GAIN_W'(26);
         damping_gain_ff  <= bfrc_pkg::GAIN_W'(128);
         initial_rate_ff  <= RATE_W'(100);
      end else if (csr_we) begin
         case (csr_index)
            bfrc_pkg::CSR_RATE_MODE: begin
               rate_mode_ff <= bfrc_pkg::rate_mode_type'(csr_wdata[bfrc_pkg::MODE_W-1:0]);
            end
            bfrc_pkg::CSR_STEP_SIZE: begin
               step_size_ff <= csr_wdata[bfrc_pkg::STEP_W-1:0];
            end
            bfrc_pkg::CSR_DECREASE_GAIN: begin
               decrease_gain_ff <= csr_wdata[bfrc_pkg::GAIN_W-1:0];
            end
            bfrc_pkg::CSR_ERROR_GAIN: begin
               error_gain_ff <= csr_wdata[bfrc_pkg::GAIN_W-1:0];
            end
            bfrc_pkg::CSR_DAMPING_GAIN: begin
               damping_gain_ff <= csr_wdata[bfrc_pkg::GAIN_W-1:0];
            end
            bfrc_pkg::CSR_INITIAL_RATE: begin
               initial_rate_ff <= csr_wdata[RATE_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign req_bus.ready      = (state_ff == ST_IDLE);
   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.new_rate   = rsp_rate_ff;
   assign rsp_bus.spacing_ns = rsp_spacing_ff;
   assign rsp_bus.clamped    = rsp_clamped_ff;

endmodule

`default_nettype wire
